// File: design/hpg_pkg.sv
// Shared types and constants of the core hotplug load governor.
package hpg_pkg;

    localparam int OPCODE_W   = 2;
    localparam int LOAD_W     = 8;
    localparam int CORES_W    = 3;
    localparam int FREQ_W     = 25;
    localparam int COUNT_W    = 6;
    localparam int THRESH_W   = 7;
    localparam int HOLDLIM_W  = 24;
    localparam int SECONDS_W  = 4;
    localparam int HOLD_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Input opcodes.
    localparam logic [OPCODE_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SUSPEND = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_RESUME  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ENABLED        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_PCT_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRING_UP_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_CEILING  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_HOLD      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ONLINE     = 3'd5;

    localparam logic [LOAD_W-1:0]    SPIKE_LOAD  = 8'd180;
    localparam logic [THRESH_W-1:0]  THRESH_MAX  = 7'd100;
    localparam logic [HOLD_W-1:0]    US_PER_SEC  = 24'd1000000;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_UP      = 3'd1,
        ACT_DOWN    = 3'd2,
        ACT_SUSPEND = 3'd3,
        ACT_RESUME  = 3'd4
    } t_action;

    typedef struct packed {
        logic                 enabled;
        logic [THRESH_W-1:0]  load_pct_limit;
        logic [COUNT_W-1:0]   bring_up_count;
        logic [COUNT_W-1:0]   count_ceiling;
        logic [HOLDLIM_W-1:0] freq_hold_limit;
        logic [SECONDS_W-1:0] min_online_seconds;
    } t_cfg;

    // Minimum online time in microseconds; settings below two seconds mean one.
    function automatic logic [HOLD_W-1:0] hold_us(input logic [SECONDS_W-1:0] secs);
        logic [HOLD_W-1:0] result;
        if (secs < 4'd2) begin
            result = US_PER_SEC;
        end else begin
            result = HOLD_W'(secs) * US_PER_SEC;
        end
        return result;
    endfunction

endpackage

// File: design/hpg_if.sv
// Channel interfaces of the core hotplug load governor: input, result and configuration.
interface hpg_in_if import hpg_pkg::*; #(
    parameter int TIME_BITS = 48
) ();
    logic                  valid;
    logic                  ready;
    logic [OPCODE_W-1:0]   opcode;
    logic [LOAD_W-1:0]     load_sum;
    logic [CORES_W-1:0]    cores_online;
    logic [FREQ_W-1:0]     extra_freq_sum;
    logic [TIME_BITS-1:0]  now_us;

    modport source (output valid, opcode, load_sum, cores_online, extra_freq_sum, now_us,
                    input ready);
    modport sink   (input valid, opcode, load_sum, cores_online, extra_freq_sum, now_us,
                    output ready);
endinterface

interface hpg_out_if import hpg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [2:0]          action;
    logic [COUNT_W-1:0]  load_count;

    modport source (output valid, action, load_count, input ready);
    modport sink   (input valid, action, load_count, output ready);
endinterface

interface hpg_cfg_if import hpg_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: design/hpg_cfg_regs.sv
// Configuration register file of the core hotplug load governor.
module hpg_cfg_regs import hpg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hpg_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled            <= 1'b0;
            r_cfg.load_pct_limit     <= 7'd80;
            r_cfg.bring_up_count     <= 6'd10;
            r_cfg.count_ceiling      <= 6'd20;
            r_cfg.freq_hold_limit    <= 24'd1500000;
            r_cfg.min_online_seconds <= 4'd1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ENABLED:        r_cfg.enabled            <= i_cfg.data[0];
                REG_LOAD_PCT_LIMIT: r_cfg.load_pct_limit     <= i_cfg.data[THRESH_W-1:0];
                REG_BRING_UP_COUNT: r_cfg.bring_up_count     <= i_cfg.data[COUNT_W-1:0];
                REG_COUNT_CEILING:  r_cfg.count_ceiling      <= i_cfg.data[COUNT_W-1:0];
                REG_FREQ_HOLD:      r_cfg.freq_hold_limit    <= i_cfg.data[HOLDLIM_W-1:0];
                REG_MIN_ONLINE:     r_cfg.min_online_seconds <= i_cfg.data[SECONDS_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// File: design/hpg_eval.sv
// Decision logic of the core hotplug load governor: action and next state for one item.
module hpg_eval import hpg_pkg::*; #(
    parameter int NUM_CORES = 4,
    parameter int TIME_BITS = 48
) (
    input  t_cfg                 i_cfg,
    input  logic [OPCODE_W-1:0]  i_opcode,
    input  logic [LOAD_W-1:0]    i_load_sum,
    input  logic [CORES_W-1:0]   i_cores_online,
    input  logic [FREQ_W-1:0]    i_extra_freq_sum,
    input  logic [TIME_BITS-1:0] i_now_us,
    input  logic [COUNT_W-1:0]   i_count,
    input  logic                 i_suspended,
    input  logic [TIME_BITS-1:0] i_last_time,
    output t_action              o_action,
    output logic [COUNT_W-1:0]   o_count,
    output logic                 o_suspended,
    output logic                 o_set_time
);

    logic                 skip;
    logic                 load_hot;
    logic [COUNT_W-1:0]   count_up;
    logic [COUNT_W-1:0]   count_down;
    logic                 few_cores;
    logic                 freq_high;
    logic [TIME_BITS-1:0] elapsed;
    logic                 hold_over;

    assign skip = (i_cores_online == 3'd1) || i_suspended ||
                  ((i_cfg.load_pct_limit == THRESH_MAX) && (i_cores_online == 3'd2)) ||
                  ((i_cfg.load_pct_limit == '0) && (int'(i_cores_online) == NUM_CORES));

    assign load_hot   = i_load_sum >= {i_cfg.load_pct_limit, 1'b0};
    assign count_up   = (i_count < i_cfg.count_ceiling) ? i_count + 1'b1 : i_count;
    assign count_down = (i_count != '0) ? i_count - 1'b1 : i_count;
    assign few_cores  = i_cores_online <= 3'd2;
    assign freq_high  = i_extra_freq_sum[FREQ_W-1:1] >= i_cfg.freq_hold_limit;

    // A time earlier than the last online mark is still inside the hold.
    assign elapsed   = i_now_us - i_last_time;
    assign hold_over = (i_now_us >= i_last_time) &&
                       (elapsed >= TIME_BITS'(hold_us(i_cfg.min_online_seconds)));

    always_comb begin
        o_action    = ACT_NONE;
        o_count     = i_count;
        o_suspended = i_suspended;
        o_set_time  = 1'b0;
        if (i_cfg.enabled) begin
            unique case (i_opcode)
                OP_TICK: begin
                    if (!skip) begin
                        if (load_hot) begin
                            o_count = count_up;
                            if (few_cores && (((i_load_sum >= SPIKE_LOAD) && (count_up >= 6'd2))
                                    || (count_up >= i_cfg.bring_up_count))) begin
                                o_set_time = 1'b1;
                                o_action   = ACT_UP;
                            end
                        end else begin
                            o_count = count_down;
                            if (!few_cores && (count_down < i_cfg.bring_up_count)) begin
                                // High frequency restarts the hold, so no take-down now.
                                if (freq_high) begin
                                    o_set_time = 1'b1;
                                end else if (hold_over) begin
                                    o_count  = '0;
                                    o_action = ACT_DOWN;
                                end
                            end
                        end
                    end
                end
                OP_SUSPEND: begin
                    o_count     = '0;
                    o_suspended = 1'b1;
                    o_action    = ACT_SUSPEND;
                end
                OP_RESUME: begin
                    o_suspended = 1'b0;
                    o_action    = ACT_RESUME;
                end
                default: ;
            endcase
        end
    end

endmodule

// File: design/core_hotplug_load_governor.sv
// Top level of the core hotplug load governor: input register, state and result register.
//
// The governor decides, once per input transfer, whether the two extra cores of a
// four-core cluster should come online, go offline, or whether a suspend or resume
// action applies. A sample tick carries the summed load of the always-on cores, the
// online core count, the summed frequency of the extra cores and a microsecond time
// stamp; a saturating high-load counter, the time of the last bring-up or hold and a
// suspended flag are kept between transfers and cleared by reset. Every input transfer
// gives exactly one result transfer carrying the action and the counter value after
// the step. An item passes through the input register and then the result
// register; the decision logic between them updates the state as the result is
// registered, so one item is taken in every cycle when the result side keeps up.
// The result register decouples the sides: while a result waits, one more item is
// taken into an empty input register, and a full input register moves on in the
// same cycle as the waiting result leaves. Configuration writes are always accepted
// and take effect at the next clock edge; they are meant to be issued while no item
// is in flight.
module core_hotplug_load_governor import hpg_pkg::*; #(
    parameter int NUM_CORES = 4,
    parameter int TIME_BITS = 48
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    hpg_cfg_if.sink  i_cfg,
    hpg_in_if.sink   i_in,
    hpg_out_if.source o_out
);

    t_cfg cfg;

    // Input register stage.
    logic                 r_s1_valid;
    logic [OPCODE_W-1:0]  r_s1_opcode;
    logic [LOAD_W-1:0]    r_s1_load_sum;
    logic [CORES_W-1:0]   r_s1_cores_online;
    logic [FREQ_W-1:0]    r_s1_extra_freq_sum;
    logic [TIME_BITS-1:0] r_s1_now_us;

    // Governor state.
    logic [COUNT_W-1:0]   r_count;
    logic                 r_suspended;
    logic [TIME_BITS-1:0] r_last_time;

    // Result register.
    logic                 r_out_valid;
    t_action              r_out_action;
    logic [COUNT_W-1:0]   r_out_count;

    t_action              n_action;
    logic [COUNT_W-1:0]   n_count;
    logic                 n_suspended;
    logic                 set_time;
    logic                 out_free;
    logic                 s1_advance;
    logic                 in_take;

    hpg_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    hpg_eval #(
        .NUM_CORES (NUM_CORES),
        .TIME_BITS (TIME_BITS)
    ) u_eval (
        .i_cfg            (cfg),
        .i_opcode         (r_s1_opcode),
        .i_load_sum       (r_s1_load_sum),
        .i_cores_online   (r_s1_cores_online),
        .i_extra_freq_sum (r_s1_extra_freq_sum),
        .i_now_us         (r_s1_now_us),
        .i_count          (r_count),
        .i_suspended      (r_suspended),
        .i_last_time      (r_last_time),
        .o_action         (n_action),
        .o_count          (n_count),
        .o_suspended      (n_suspended),
        .o_set_time       (set_time)
    );

    // The result register is free when empty or when its result leaves this cycle.
    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_advance = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;
    assign in_take    = i_in.valid && i_in.ready;

    assign o_out.valid      = r_out_valid;
    assign o_out.action     = r_out_action;
    assign o_out.load_count = r_out_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_suspended <= 1'b0;
            r_last_time <= '0;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_advance) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
                r_suspended <= n_suspended;
                if (set_time) begin
                    r_last_time <= r_s1_now_us;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_opcode         <= i_in.opcode;
            r_s1_load_sum       <= i_in.load_sum;
            r_s1_cores_online   <= i_in.cores_online;
            r_s1_extra_freq_sum <= i_in.extra_freq_sum;
            r_s1_now_us         <= i_in.now_us;
        end
        if (s1_advance) begin
            r_out_action <= n_action;
            r_out_count  <= n_count;
        end
    end

endmodule

// File: dv/tb_core_hotplug_load_governor.sv
// Self-checking testbench of the core hotplug load governor: scoreboard, stimulus and checks.
module tb_core_hotplug_load_governor;
    import hpg_pkg::*;

    localparam int NUM_CORES   = 4;
    localparam int TIME_BITS   = 48;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 125;
    localparam int NUM_PHASES  = 8;

    // The opcode value that the governor has no use for.
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    localparam longint unsigned FREQ_MAX = 64'h1FF_FFFF;
    localparam longint unsigned TIME_MASK = 64'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [OPCODE_W-1:0]  opcode;
        logic [LOAD_W-1:0]    load_sum;
        logic [CORES_W-1:0]   cores_online;
        logic [FREQ_W-1:0]    extra_freq_sum;
        logic [TIME_BITS-1:0] now_us;
    } t_sample;

    typedef struct packed {
        t_action            action;
        logic [COUNT_W-1:0] load_count;
    } t_decision;

    // The scoreboard keeps its own copy of the registers and of the governor state.
    // Every accepted input transfer is turned into the decision the governor must
    // return, and the result transfers are matched against those in order.
    class hotplug_decision_board;
        t_cfg                  regs;
        logic [COUNT_W-1:0]    busy_count;
        logic [TIME_BITS-1:0]  last_online_us;
        bit                    is_suspended;
        t_decision             pending_decisions[$];
        int                    mismatches;

        function new();
            regs.enabled            = 1'b0;
            regs.load_pct_limit     = 7'd80;
            regs.bring_up_count     = 6'd10;
            regs.count_ceiling      = 6'd20;
            regs.freq_hold_limit    = 24'd1500000;
            regs.min_online_seconds = 4'd1;
            busy_count      = '0;
            last_online_us  = '0;
            is_suspended    = 1'b0;
            mismatches      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ENABLED:        regs.enabled            = data[0];
                REG_LOAD_PCT_LIMIT: regs.load_pct_limit     = data[THRESH_W-1:0];
                REG_BRING_UP_COUNT: regs.bring_up_count     = data[COUNT_W-1:0];
                REG_COUNT_CEILING:  regs.count_ceiling      = data[COUNT_W-1:0];
                REG_FREQ_HOLD:      regs.freq_hold_limit    = data[HOLDLIM_W-1:0];
                REG_MIN_ONLINE:     regs.min_online_seconds = data[SECONDS_W-1:0];
                default: ;
            endcase
        endfunction

        function t_decision next_decision(t_sample s);
            t_decision       d;
            t_action         act;
            longint unsigned now;
            longint unsigned last;
            longint unsigned hold;
            act = ACT_NONE;
            now = 64'(s.now_us);
            if (regs.enabled) begin
                case (s.opcode)
                    OP_TICK: begin
                        // Ticks with one core online, while suspended, or at the two
                        // threshold extremes with the matching core count are skipped.
                        if (s.cores_online == 1 || is_suspended) begin
                        end else if (regs.load_pct_limit == THRESH_MAX &&
                                     s.cores_online == 2) begin
                        end else if (regs.load_pct_limit == 0 &&
                                     int'(s.cores_online) == NUM_CORES) begin
                        end else if (int'(s.load_sum) >= 2 * int'(regs.load_pct_limit)) begin
                            // High load: the counter saturates at the ceiling but is
                            // never pulled down to it when the ceiling was lowered.
                            if (busy_count < regs.count_ceiling)
                                busy_count = busy_count + 1'b1;
                            if (s.cores_online <= 2 &&
                                ((s.load_sum >= SPIKE_LOAD && busy_count >= 2) ||
                                 busy_count >= regs.bring_up_count)) begin
                                last_online_us = s.now_us;
                                act = ACT_UP;
                            end
                        end else begin
                            if (busy_count != 0)
                                busy_count = busy_count - 1'b1;
                            if (s.cores_online > 2 && busy_count < regs.bring_up_count) begin
                                // A busy pair of extra cores restarts the hold.
                                if ((s.extra_freq_sum >> 1) >= regs.freq_hold_limit)
                                    last_online_us = s.now_us;
                                last = 64'(last_online_us);
                                if (regs.min_online_seconds > 1)
                                    hold = 64'(regs.min_online_seconds) * 64'(US_PER_SEC);
                                else
                                    hold = 64'(US_PER_SEC);
                                // Time running backward counts as still inside the hold.
                                if (!(now < last || now - last < hold)) begin
                                    busy_count = '0;
                                    act = ACT_DOWN;
                                end
                            end
                        end
                    end
                    OP_SUSPEND: begin
                        busy_count = '0;
                        is_suspended = 1'b1;
                        act = ACT_SUSPEND;
                    end
                    OP_RESUME: begin
                        is_suspended = 1'b0;
                        act = ACT_RESUME;
                    end
                    default: ;
                endcase
            end
            d.action = act;
            d.load_count = busy_count;
            return d;
        endfunction

        function void note_sample(t_sample s);
            pending_decisions.push_back(next_decision(s));
        endfunction

        function void check_decision(logic [2:0] act, logic [COUNT_W-1:0] cnt);
            t_decision want;
            if (pending_decisions.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: action %0d count %0d", act, cnt);
                mismatches++;
            end else begin
                want = pending_decisions.pop_front();
                if (act !== want.action || cnt !== want.load_count) begin
                    if (mismatches < 10)
                        $display("mismatch: expected action %0d count %0d, got action %0d count %0d",
                                 want.action, want.load_count, act, cnt);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    hpg_cfg_if                         cfg_if ();
    hpg_in_if  #(.TIME_BITS(TIME_BITS)) in_if ();
    hpg_out_if                         out_if ();

    core_hotplug_load_governor #(
        .NUM_CORES(NUM_CORES),
        .TIME_BITS(TIME_BITS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_if.sink),
        .i_in   (in_if.sink),
        .o_out  (out_if.source)
    );

    hotplug_decision_board board;
    int send_idle_pct = 14;
    int recv_idle_pct = 64;
    int cycle_count   = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Watchdog: a run that hangs on a handshake ends here as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL core_hotplug_load_governor");
            $finish;
        end
    end

    // Result side: every result transfer is checked against the oldest expected
    // decision, and ready is dropped at random to stall the governor.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            board.check_decision(out_if.action, out_if.load_count);
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic t_sample mk_sample(logic [OPCODE_W-1:0] op, int load, int cores,
                                          longint unsigned freq, longint unsigned now);
        t_sample s;
        s.opcode         = op;
        s.load_sum       = LOAD_W'(load);
        s.cores_online   = CORES_W'(cores);
        s.extra_freq_sum = FREQ_W'(freq);
        s.now_us         = TIME_BITS'(now);
        return s;
    endfunction

    // One input transfer, preceded by a random number of idle cycles. Valid stays
    // high after the transfer so that back-to-back items need no extra edge.
    task automatic send_item(input t_sample s);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid          <= 1'b1;
        in_if.opcode         <= s.opcode;
        in_if.load_sum       <= s.load_sum;
        in_if.cores_online   <= s.cores_online;
        in_if.extra_freq_sum <= s.extra_freq_sum;
        in_if.now_us         <= s.now_us;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        board.note_sample(s);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint unsigned data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= CFG_DATA_W'(data);
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
        board.write_reg(idx, CFG_DATA_W'(data));
    endtask

    // Writes the whole register set; only called while the governor is idle.
    task automatic program_regs(input int en, input int thr, input int bring, input int ceil,
                                input longint unsigned hold_khz, input int secs);
        write_reg(REG_ENABLED, en);
        write_reg(REG_LOAD_PCT_LIMIT, thr);
        write_reg(REG_BRING_UP_COUNT, bring);
        write_reg(REG_COUNT_CEILING, ceil);
        write_reg(REG_FREQ_HOLD, hold_khz);
        write_reg(REG_MIN_ONLINE, secs);
        cfg_if.valid <= 1'b0;
    endtask

    // Stops the input side and waits until every expected result has come out,
    // then a few cycles more so that nothing is still in the pipeline.
    task automatic settle();
        in_if.valid <= 1'b0;
        while (board.pending_decisions.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        longint unsigned clock_us;
        longint unsigned freq;
        int              thr2;
        int              cores_now;
        bit              high_regime;
        int              r;
        t_sample         s;

        cfg_if.valid         = 1'b0;
        cfg_if.index         = '0;
        cfg_if.data          = '0;
        in_if.valid          = 1'b0;
        in_if.opcode         = OP_TICK;
        in_if.load_sum       = '0;
        in_if.cores_online   = '0;
        in_if.extra_freq_sum = '0;
        in_if.now_us         = '0;
        out_if.ready         = 1'b0;
        board = new();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Out of reset the governor is disabled: every opcode gives no action.
        send_item(mk_sample(OP_TICK, 200, 2, 0, 1000));
        send_item(mk_sample(OP_SUSPEND, 0, 2, 0, 2000));
        send_item(mk_sample(OP_RESUME, 0, 2, 0, 3000));
        settle();

        program_regs(1, 80, 10, 20, 1500000, 1);
        // The first high tick is below the spike count; the second is a load spike.
        send_item(mk_sample(OP_TICK, 200, 2, 0, 1000));
        send_item(mk_sample(OP_TICK, 255, 2, 0, 2000));
        // One core online: the tick is skipped.
        send_item(mk_sample(OP_TICK, 0, 1, 0, 3000));
        // Low load inside the hold, then a busy pair restarts the hold.
        send_item(mk_sample(OP_TICK, 100, 4, 0, 500000));
        send_item(mk_sample(OP_TICK, 100, 4, 3000000, 1500000));
        // Hold expired: take-down.
        send_item(mk_sample(OP_TICK, 100, 4, 0, 2600000));
        // Time running backward stays inside the hold.
        send_item(mk_sample(OP_TICK, 100, 4, 0, 100));
        send_item(mk_sample(OP_TICK, 255, 7, FREQ_MAX, TIME_MASK));
        // Repeated suspend and resume events, a tick while suspended, the unused opcode.
        send_item(mk_sample(OP_SUSPEND, 0, 4, 0, 0));
        send_item(mk_sample(OP_SUSPEND, 0, 4, 0, 0));
        send_item(mk_sample(OP_TICK, 200, 2, 0, 4000000));
        send_item(mk_sample(OP_RESUME, 0, 4, 0, 0));
        send_item(mk_sample(OP_RESUME, 0, 4, 0, 0));
        send_item(mk_sample(OP_UNUSED, 255, 7, FREQ_MAX, TIME_MASK));
        settle();

        // Threshold at its top with two cores online is skipped.
        program_regs(1, 100, 0, 63, 0, 15);
        send_item(mk_sample(OP_TICK, 150, 2, 0, 5000000));
        send_item(mk_sample(OP_TICK, 0, 4, 0, 30000000));
        settle();

        // Threshold zero with all cores online is skipped.
        program_regs(1, 0, 63, 0, 24'hFFFFFF, 0);
        send_item(mk_sample(OP_TICK, 50, 4, 0, 31000000));
        send_item(mk_sample(OP_TICK, 0, 3, FREQ_MAX, 32000000));
        settle();

        // Raise the counter, then lower the ceiling beneath it.
        program_regs(1, 50, 63, 63, 1500000, 2);
        send_item(mk_sample(OP_TICK, 200, 2, 0, 33000000));
        send_item(mk_sample(OP_TICK, 200, 2, 0, 33100000));
        settle();
        program_regs(1, 50, 63, 1, 1500000, 2);
        send_item(mk_sample(OP_TICK, 200, 2, 0, 33200000));
        send_item(mk_sample(OP_TICK, 10, 2, 0, 33300000));
        settle();

        // Random phases: typical settings, both extremes, then random settings.
        // The sender idles lightly and the receiver heavily first, then the other
        // way round, and the last phases run with no idling at all.
        clock_us    = 40000000;
        cores_now   = 2;
        high_regime = 1'b0;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            if (ph < 3) begin
                send_idle_pct = 14;
                recv_idle_pct = 64;
            end else if (ph < 6) begin
                send_idle_pct = 64;
                recv_idle_pct = 14;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                0: program_regs(1, 80, 10, 20, 1500000, 1);
                1: program_regs(1, 0, 0, 0, 0, 0);
                2: program_regs(1, 127, 63, 63, 24'hFFFFFF, 15);
                default: program_regs(($urandom_range(0, 9) != 0),
                                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                                  : $urandom_range(20, 100),
                                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                                  : $urandom_range(1, 10),
                                      $urandom_range(0, 63),
                                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                                                  : $urandom_range(500000, 2000000),
                                      $urandom_range(0, 15));
            endcase
            thr2 = 2 * int'(board.regs.load_pct_limit);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Time mostly moves in sample steps, with occasional jumps both ways.
                r = $urandom_range(0, 99);
                if (r < 5 && clock_us > 2000000)
                    clock_us = clock_us - $urandom_range(0, 2000000);
                else if (r < 8)
                    clock_us = {$urandom, $urandom} & TIME_MASK;
                else if (r < 13)
                    clock_us = clock_us + $urandom_range(1000000, 6000000);
                else
                    clock_us = clock_us + $urandom_range(100000, 150000);
                clock_us = clock_us & TIME_MASK;

                // Load comes in streaks so that the counter climbs and drains.
                if ($urandom_range(0, 99) < 8)
                    high_regime = !high_regime;
                if ($urandom_range(0, 99) < 5)
                    cores_now = ($urandom_range(0, 9) < 8) ? (($urandom_range(0, 1) != 0) ? 4 : 2)
                                                           : $urandom_range(0, 7);
                s.opcode = OP_TICK;
                if ($urandom_range(0, 99) < 3)
                    s.load_sum = LOAD_W'($urandom_range(0, 255));
                else if (high_regime || thr2 == 0)
                    s.load_sum = LOAD_W'($urandom_range((thr2 > 255) ? 255 : thr2, 255));
                else
                    s.load_sum = LOAD_W'($urandom_range(0, (thr2 > 256) ? 255 : thr2 - 1));
                s.cores_online = CORES_W'(($urandom_range(0, 99) < 3) ? $urandom_range(0, 7)
                                                                      : cores_now);
                if ($urandom_range(0, 9) < 3)
                    freq = $urandom_range(0, FREQ_MAX);
                else
                    freq = $urandom_range(0, 4 * int'(board.regs.freq_hold_limit));
                s.extra_freq_sum = FREQ_W'((freq > FREQ_MAX) ? FREQ_MAX : freq);
                s.now_us = TIME_BITS'(clock_us);

                r = $urandom_range(0, 99);
                if (r < 3)
                    s.opcode = OP_SUSPEND;
                else if (r < 7)
                    s.opcode = OP_RESUME;
                else if (r < 9)
                    s.opcode = OP_UNUSED;
                send_item(s);
            end
        end
        settle();

        if (board.mismatches == 0 && board.pending_decisions.size() == 0) begin
            $display("PASS core_hotplug_load_governor");
        end else begin
            $display("FAIL core_hotplug_load_governor");
        end
        $finish;
    end

endmodule
